[design/pwrk_pkg.sv]
// Package: shared constants, link and control types for the power-sum / top-k block.
package pwrk_pkg;

  // Sizing of the sorted list and of the sample path
  localparam int TOP_COUNT   = 256;
  localparam int SAMPLE_BITS = 16;

  // Fixed field widths of the channels
  localparam int SAMPLE_W  = 16;
  localparam int RANK_W    = 8;
  localparam int COUNT_W   = 48;
  localparam int ONE_W     = 48;
  localparam int TWO_W     = 63;
  localparam int THREE_W   = 64;
  localparam int FOUR_W    = 63;
  localparam int OUT_MAG_W = 16;
  localparam int KEPT_W    = 9;

  // Derived widths of the arithmetic
  localparam int MAG_W  = SAMPLE_BITS;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int CUBE_W = 3 * SAMPLE_BITS;
  localparam int QUAD_W = 2 * SQ_W;
  localparam int FILL_W = $clog2(TOP_COUNT + 1);
  localparam int CMP_W  = (FILL_W > RANK_W) ? FILL_W : RANK_W;

  // Ranked read: a registered first level and a combinational second level of 16-way selection
  localparam int GROUP_BITS = 4;
  localparam int GROUP_SIZE = 1 << GROUP_BITS;
  localparam int GROUP_CNT  = 1 << (RANK_W - GROUP_BITS);
  localparam int READ_DEPTH = GROUP_SIZE * GROUP_CNT;

  // Item kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Broadcast to every cell of the sorted chain
  typedef struct packed {
    logic             en;
    logic [MAG_W-1:0] mag;
  } pwrk_ins_t;

  // What a cell hands to its right neighbor
  typedef struct packed {
    logic             gt;
    logic [MAG_W-1:0] value;
  } pwrk_link_t;

  // Step strobes for the moment datapath
  typedef struct packed {
    logic square;
    logic power;
    logic accum;
  } pwrk_mctl_t;

  // Running statistics
  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    logic signed [ONE_W-1:0]   one;
    logic [TWO_W-1:0]          two;
    logic signed [THREE_W-1:0] three;
    logic [FOUR_W-1:0]         four;
    logic [MAG_W-1:0]          peak;
    logic                      ovf;
  } pwrk_stats_t;

endpackage

[design/pwrk_if.sv]
// Interfaces: input item channel and result channel with valid/ready handshake.
interface pwrk_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [pwrk_pkg::SAMPLE_W-1:0]   sample;
  logic [pwrk_pkg::RANK_W-1:0]            rank;

  modport source (output valid, kind, sample, rank, input ready);
  modport sink   (input valid, kind, sample, rank, output ready);
endinterface

interface pwrk_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [pwrk_pkg::COUNT_W-1:0]           nonzero_count;
  logic signed [pwrk_pkg::ONE_W-1:0]      power_one;
  logic [pwrk_pkg::TWO_W-1:0]             power_two;
  logic signed [pwrk_pkg::THREE_W-1:0]    power_three;
  logic [pwrk_pkg::FOUR_W-1:0]            power_four;
  logic [pwrk_pkg::OUT_MAG_W-1:0]         peak_magnitude;
  logic [pwrk_pkg::OUT_MAG_W-1:0]         ranked_magnitude;
  logic                                   ranked_present;
  logic [pwrk_pkg::KEPT_W-1:0]            kept_count;
  logic                                   overflow_flag;

  modport source (output valid, nonzero_count, power_one, power_two, power_three, power_four,
                  peak_magnitude, ranked_magnitude, ranked_present, kept_count,
                  overflow_flag, input ready);
  modport sink   (input valid, nonzero_count, power_one, power_two, power_three, power_four,
                  peak_magnitude, ranked_magnitude, ranked_present, kept_count,
                  overflow_flag, output ready);
endinterface

[design/pwrk_cell.sv]
// One cell of the sorted chain: holds one list entry, compares and shifts on insert.
module pwrk_cell (
  input  logic                 clk,
  input  pwrk_pkg::pwrk_ins_t  ins,
  input  logic                 valid,
  input  pwrk_pkg::pwrk_link_t left,
  output pwrk_pkg::pwrk_link_t right
);

  logic [pwrk_pkg::MAG_W-1:0] value;

  // Entry stays put when it is strictly greater than the new magnitude
  assign right.gt    = valid && (value > ins.mag);
  assign right.value = value;

  // Take the new magnitude at the insert point, the left entry past it
  always_ff @(posedge clk) begin
    if (ins.en && !right.gt) begin
      value <= left.gt ? ins.mag : left.value;
    end
  end

endmodule

[design/pwrk_chain.sv]
// Sorted chain of cells with fill count; two-level ranked read, first registered.
module pwrk_chain (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pwrk_pkg::pwrk_ins_t                  ins,
  input  logic [pwrk_pkg::RANK_W-1:0]          rank,
  output logic [pwrk_pkg::FILL_W-1:0]          fill,
  output logic [pwrk_pkg::OUT_MAG_W-1:0]       ranked
);

  pwrk_pkg::pwrk_link_t         link       [pwrk_pkg::TOP_COUNT];
  logic [pwrk_pkg::MAG_W-1:0]   rd_val     [pwrk_pkg::READ_DEPTH];
  logic [pwrk_pkg::MAG_W-1:0]   group_pick [pwrk_pkg::GROUP_CNT];
  logic [pwrk_pkg::GROUP_BITS-1:0]          rank_lo;
  logic [pwrk_pkg::RANK_W-pwrk_pkg::GROUP_BITS-1:0] rank_hi;

  assign rank_lo = rank[pwrk_pkg::GROUP_BITS-1:0];
  assign rank_hi = rank[pwrk_pkg::RANK_W-1:pwrk_pkg::GROUP_BITS];

  // Row of cells, each fed by its left neighbor
  for (genvar i = 0; i < pwrk_pkg::TOP_COUNT; i++) begin : g_cell
    localparam logic [pwrk_pkg::FILL_W-1:0] IDX = pwrk_pkg::FILL_W'(i);
    pwrk_pkg::pwrk_link_t left;
    logic                 valid;

    assign valid = IDX < fill;
    if (i == 0) begin : g_head
      assign left = '{gt: 1'b1, value: '0};
    end else begin : g_body
      assign left = link[i-1];
    end

    pwrk_cell u_cell (
      .clk   (clk),
      .ins   (ins),
      .valid (valid),
      .left  (left),
      .right (link[i])
    );
  end

  // Read view padded to the full rank range
  for (genvar r = 0; r < pwrk_pkg::READ_DEPTH; r++) begin : g_rd
    if (r < pwrk_pkg::TOP_COUNT) begin : g_on
      assign rd_val[r] = link[r].value;
    end else begin : g_off
      assign rd_val[r] = '0;
    end
  end

  // First read level: one pick per group of cells
  for (genvar g = 0; g < pwrk_pkg::GROUP_CNT; g++) begin : g_grp
    logic [pwrk_pkg::MAG_W-1:0] grp [pwrk_pkg::GROUP_SIZE];
    for (genvar j = 0; j < pwrk_pkg::GROUP_SIZE; j++) begin : g_ent
      assign grp[j] = rd_val[g * pwrk_pkg::GROUP_SIZE + j];
    end
    always_ff @(posedge clk) begin
      group_pick[g] <= grp[rank_lo];
    end
  end

  // Second read level is picked by the top bits of the rank
  assign ranked = pwrk_pkg::OUT_MAG_W'(group_pick[rank_hi]);

  // Fill count saturates at the list size
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ins.en && (fill < pwrk_pkg::FILL_W'(pwrk_pkg::TOP_COUNT))) begin
      fill <= fill + pwrk_pkg::FILL_W'(1);
    end
  end

endmodule

[design/pwrk_moments.sv]
// Power-sum datapath: square, cube and fourth power, saturating accumulators, peak.
module pwrk_moments (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pwrk_pkg::pwrk_mctl_t                    ctl,
  input  logic signed [pwrk_pkg::SAMPLE_BITS-1:0] x,
  input  logic [pwrk_pkg::MAG_W-1:0]              mag,
  output pwrk_pkg::pwrk_stats_t                   stats
);

  localparam logic [pwrk_pkg::ONE_W-1:0] ONE_MAX = {1'b0, {(pwrk_pkg::ONE_W-1){1'b1}}};
  localparam logic [pwrk_pkg::ONE_W-1:0] ONE_MIN = {1'b1, {(pwrk_pkg::ONE_W-1){1'b0}}};
  localparam logic [pwrk_pkg::THREE_W-1:0] THREE_MAX =
    {1'b0, {(pwrk_pkg::THREE_W-1){1'b1}}};
  localparam logic [pwrk_pkg::THREE_W-1:0] THREE_MIN =
    {1'b1, {(pwrk_pkg::THREE_W-1){1'b0}}};

  logic [pwrk_pkg::SQ_W-1:0]            sq;
  logic signed [pwrk_pkg::CUBE_W-1:0]   cube;
  logic [pwrk_pkg::QUAD_W-1:0]          quad;
  logic signed [pwrk_pkg::ONE_W:0]      sum1;
  logic [pwrk_pkg::TWO_W:0]             sum2;
  logic signed [pwrk_pkg::THREE_W:0]    sum3;
  logic [pwrk_pkg::FOUR_W:0]            sum4;
  pwrk_pkg::pwrk_stats_t                stats_next;

  // Products, one multiplier level per step
  always_ff @(posedge clk) begin
    if (ctl.square) begin
      sq <= pwrk_pkg::SQ_W'(mag) * pwrk_pkg::SQ_W'(mag);
    end
    if (ctl.power) begin
      cube <= pwrk_pkg::CUBE_W'($signed({1'b0, sq})) * pwrk_pkg::CUBE_W'(x);
      quad <= pwrk_pkg::QUAD_W'(sq) * pwrk_pkg::QUAD_W'(sq);
    end
  end

  // Wide sums with one guard bit each
  assign sum1 = (pwrk_pkg::ONE_W+1)'(stats.one) + (pwrk_pkg::ONE_W+1)'(x);
  assign sum2 = (pwrk_pkg::TWO_W+1)'(stats.two) + (pwrk_pkg::TWO_W+1)'(sq);
  assign sum3 = (pwrk_pkg::THREE_W+1)'(stats.three) + (pwrk_pkg::THREE_W+1)'(cube);
  assign sum4 = (pwrk_pkg::FOUR_W+1)'(stats.four) + (pwrk_pkg::FOUR_W+1)'(quad);

  // Saturation and sticky overflow
  always_comb begin
    stats_next = stats;
    if (x != '0) begin
      if (&stats.count) begin
        stats_next.ovf = 1'b1;
      end else begin
        stats_next.count = stats.count + pwrk_pkg::COUNT_W'(1);
      end
    end
    if (sum1[pwrk_pkg::ONE_W] != sum1[pwrk_pkg::ONE_W-1]) begin
      stats_next.one = sum1[pwrk_pkg::ONE_W] ? ONE_MIN : ONE_MAX;
      stats_next.ovf = 1'b1;
    end else begin
      stats_next.one = sum1[pwrk_pkg::ONE_W-1:0];
    end
    if (sum2[pwrk_pkg::TWO_W]) begin
      stats_next.two = '1;
      stats_next.ovf = 1'b1;
    end else begin
      stats_next.two = sum2[pwrk_pkg::TWO_W-1:0];
    end
    if (sum3[pwrk_pkg::THREE_W] != sum3[pwrk_pkg::THREE_W-1]) begin
      stats_next.three = sum3[pwrk_pkg::THREE_W] ? THREE_MIN : THREE_MAX;
      stats_next.ovf   = 1'b1;
    end else begin
      stats_next.three = sum3[pwrk_pkg::THREE_W-1:0];
    end
    if (sum4[pwrk_pkg::FOUR_W]) begin
      stats_next.four = '1;
      stats_next.ovf  = 1'b1;
    end else begin
      stats_next.four = sum4[pwrk_pkg::FOUR_W-1:0];
    end
    if (mag > stats.peak) begin
      stats_next.peak = mag;
    end
  end

  // Accumulator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (ctl.accum) begin
      stats <= stats_next;
    end
  end

endmodule

[design/power_sums_with_top_k.sv]
// Top level: running power sums of a sample stream with a sorted top-k magnitude list.
//
// Channels: items (sink) carries kind, sample and rank; results (source) carries the
// statistics after the item and the list entry at the requested rank. Both use
// valid/ready; a transfer happens at a rising edge with valid and ready high.
// Kind 0 adds the sample (low SAMPLE_BITS bits, two's complement); kind 1 only reads.
// Every item gives exactly one result.
// One item is in work at a time: the block takes a new item only after the previous
// one has gone through the accept step, the square, the cube and fourth-power
// multiplies, the accumulate step and the delivery step, which loads the result into
// the output register. A new item is taken while the previous result still waits there.
// The sorted list is a row of TOP_COUNT compare-and-shift cells; a magnitude is
// inserted into all of them in the same cycle. The ranked entry is read through two
// 16-way selection levels, the first registered and the second combinational.
// Reset (rst, synchronous) clears the sums, count, peak, list fill and overflow
// flag; list contents need no clearing. When the receiver stalls, the result holds
// and the block stops taking items once a second result is ready to leave.
module power_sums_with_top_k (
  input  logic             clk,
  input  logic             rst,
  pwrk_in_if.sink          items,
  pwrk_out_if.source       results
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_POWER,
    ST_ACCUM,
    ST_DELIVER
  } state_t;

  state_t                                  state;
  logic                                    kind;
  logic signed [pwrk_pkg::SAMPLE_BITS-1:0] x;
  logic [pwrk_pkg::RANK_W-1:0]             rank;
  logic [pwrk_pkg::MAG_W-1:0]              mag;
  logic                                    out_free;
  logic                                    adding;
  pwrk_pkg::pwrk_ins_t                     ins;
  pwrk_pkg::pwrk_mctl_t                    mctl;
  pwrk_pkg::pwrk_stats_t                   stats;
  logic [pwrk_pkg::FILL_W-1:0]             fill;
  logic [pwrk_pkg::OUT_MAG_W-1:0]          ranked;
  logic                                    present;

  assign adding   = (kind == pwrk_pkg::KIND_ADD);
  assign mag      = x[pwrk_pkg::SAMPLE_BITS-1] ? unsigned'(-x) : unsigned'(x);
  assign out_free = !results.valid || results.ready;
  assign items.ready = (state == ST_IDLE);

  // Step strobes
  assign ins.en      = (state == ST_SQUARE) && adding && (mag != '0);
  assign ins.mag     = mag;
  assign mctl.square = (state == ST_SQUARE);
  assign mctl.power  = (state == ST_POWER);
  assign mctl.accum  = (state == ST_ACCUM) && adding;

  assign present = pwrk_pkg::CMP_W'(rank) < pwrk_pkg::CMP_W'(fill);

  pwrk_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .ins    (ins),
    .rank   (rank),
    .fill   (fill),
    .ranked (ranked)
  );

  pwrk_moments u_moments (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .x     (x),
    .mag   (mag),
    .stats (stats)
  );

  // Item capture
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      kind <= items.kind;
      x    <= items.sample[pwrk_pkg::SAMPLE_BITS-1:0];
      rank <= items.rank;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      results.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (items.valid) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: state <= ST_POWER;
        ST_POWER:  state <= ST_ACCUM;
        ST_ACCUM:  state <= ST_DELIVER;
        ST_DELIVER: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // Load the result from the delivery step, drop valid once it is taken
      if ((state == ST_DELIVER) && out_free) begin
        results.valid            <= 1'b1;
        results.nonzero_count    <= stats.count;
        results.power_one        <= stats.one;
        results.power_two        <= stats.two;
        results.power_three      <= stats.three;
        results.power_four       <= stats.four;
        results.peak_magnitude   <= pwrk_pkg::OUT_MAG_W'(stats.peak);
        results.ranked_magnitude <= present ? ranked : '0;
        results.ranked_present   <= present;
        results.kept_count       <= pwrk_pkg::KEPT_W'(fill);
        results.overflow_flag    <= stats.ovf;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  // List never holds more than its size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= pwrk_pkg::FILL_W'(pwrk_pkg::TOP_COUNT))
    else $error("list fill beyond size");

  // A result is only raised out of the delivery step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state == ST_DELIVER))
    else $error("result raised outside delivery");

  // Overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    stats.ovf |=> stats.ovf)
    else $error("overflow flag cleared");

  // A present ranked entry is a nonzero magnitude
  a_rank_nonzero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ranked_present |-> results.ranked_magnitude != '0)
    else $error("present ranked entry is zero");
`endif

endmodule

[tb/tb_power_sums_with_top_k.sv]
// Testbench for power_sums_with_top_k: directed and random items checked against a predictor.
module tb_power_sums_with_top_k;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 470;
  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN64 = -MAX64 - 1;
  localparam longint unsigned MASK48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned MASK63 = 64'h7FFF_FFFF_FFFF_FFFF;

  // One result as it leaves the block
  typedef struct packed {
    logic [pwrk_pkg::COUNT_W-1:0]   nonzero_count;
    logic [pwrk_pkg::ONE_W-1:0]     power_one;
    logic [pwrk_pkg::TWO_W-1:0]     power_two;
    logic [pwrk_pkg::THREE_W-1:0]   power_three;
    logic [pwrk_pkg::FOUR_W-1:0]    power_four;
    logic [pwrk_pkg::OUT_MAG_W-1:0] peak_magnitude;
    logic [pwrk_pkg::OUT_MAG_W-1:0] ranked_magnitude;
    logic                           ranked_present;
    logic [pwrk_pkg::KEPT_W-1:0]    kept_count;
    logic                           overflow_flag;
  } stats_result_t;

  typedef struct {
    logic                          kind;
    logic signed [15:0]            sample;
    logic [pwrk_pkg::RANK_W-1:0]   rank;
  } item_t;

  // Running moments and sorted magnitudes, with the results still owed
  class moments_scoreboard;
    longint unsigned nz_count, sum_sq, sum_quad;
    longint          sum_lin, sum_cube;
    int              peak_mag, fill;
    int              top_list [pwrk_pkg::TOP_COUNT];
    bit              saturated;
    stats_result_t   expected_stats_q [$];
    int              errors;

    function new();
      nz_count = 0; sum_sq = 0; sum_quad = 0;
      sum_lin = 0; sum_cube = 0;
      peak_mag = 0; fill = 0; saturated = 0; errors = 0;
    endfunction

    function int pending();
      return expected_stats_q.size();
    endfunction

    // Accepted item: update the sums and the list, queue the result it owes
    function void take_item(logic kind, logic signed [15:0] sample,
                            logic [pwrk_pkg::RANK_W-1:0] rank);
      longint          x, lin, cube;
      longint unsigned mag, sq;
      int              pos, last, i;
      stats_result_t   want;
      if (kind == pwrk_pkg::KIND_ADD) begin
        x = sample;
        mag = (x < 0) ? -x : x;
        sq = mag * mag;
        if (x != 0) begin
          if (nz_count >= MASK48) begin
            nz_count = MASK48;
            saturated = 1;
          end else begin
            nz_count++;
          end
        end
        lin = sum_lin + x;
        if (lin > MAX48) begin lin = MAX48; saturated = 1; end
        if (lin < MIN48) begin lin = MIN48; saturated = 1; end
        sum_lin = lin;
        sum_sq += sq;
        if (sum_sq > MASK63) begin sum_sq = MASK63; saturated = 1; end
        cube = x * x * x;
        if (cube > 0 && sum_cube > MAX64 - cube) begin
          sum_cube = MAX64;
          saturated = 1;
        end else if (cube < 0 && sum_cube < MIN64 - cube) begin
          sum_cube = MIN64;
          saturated = 1;
        end else begin
          sum_cube += cube;
        end
        sum_quad += sq * sq;
        if (sum_quad > MASK63) begin sum_quad = MASK63; saturated = 1; end
        if (mag > peak_mag) peak_mag = int'(mag);
        // Insert after larger entries, ahead of equal ones; a full list drops its tail
        if (mag != 0) begin
          pos = 0;
          while (pos < fill && top_list[pos] > int'(mag)) pos++;
          if (pos < pwrk_pkg::TOP_COUNT) begin
            last = (fill < pwrk_pkg::TOP_COUNT) ? fill : pwrk_pkg::TOP_COUNT - 1;
            for (i = last; i > pos; i--) top_list[i] = top_list[i-1];
            top_list[pos] = int'(mag);
            if (fill < pwrk_pkg::TOP_COUNT) fill++;
          end
        end
      end
      want.nonzero_count    = nz_count[pwrk_pkg::COUNT_W-1:0];
      want.power_one        = sum_lin[pwrk_pkg::ONE_W-1:0];
      want.power_two        = sum_sq[pwrk_pkg::TWO_W-1:0];
      want.power_three      = sum_cube;
      want.power_four       = sum_quad[pwrk_pkg::FOUR_W-1:0];
      want.peak_magnitude   = 16'(peak_mag);
      want.ranked_present   = int'(rank) < fill;
      want.ranked_magnitude = want.ranked_present ? 16'(top_list[int'(rank)]) : '0;
      want.kept_count       = pwrk_pkg::KEPT_W'(fill);
      want.overflow_flag    = saturated;
      expected_stats_q.push_back(want);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_stats(stats_result_t got);
      stats_result_t want;
      if (expected_stats_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing actual %0h", $time, got);
        return;
      end
      want = expected_stats_q.pop_front();
      check_field("nonzero_count", want.nonzero_count, got.nonzero_count);
      check_field("power_one", want.power_one, got.power_one);
      check_field("power_two", want.power_two, got.power_two);
      check_field("power_three", want.power_three, got.power_three);
      check_field("power_four", want.power_four, got.power_four);
      check_field("peak_magnitude", want.peak_magnitude, got.peak_magnitude);
      check_field("ranked_magnitude", want.ranked_magnitude, got.ranked_magnitude);
      check_field("ranked_present", want.ranked_present, got.ranked_present);
      check_field("kept_count", want.kept_count, got.kept_count);
      check_field("overflow_flag", want.overflow_flag, got.overflow_flag);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cycle_count = 0;

  moments_scoreboard sb = new();

  pwrk_in_if  items_ch();
  pwrk_out_if results_ch();

  power_sums_with_top_k dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Transfers on both channels, seen at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (items_ch.valid && items_ch.ready)
        sb.take_item(items_ch.kind, items_ch.sample, items_ch.rank);
      if (results_ch.valid && results_ch.ready)
        sb.check_stats('{results_ch.nonzero_count, results_ch.power_one,
                         results_ch.power_two, results_ch.power_three,
                         results_ch.power_four, results_ch.peak_magnitude,
                         results_ch.ranked_magnitude, results_ch.ranked_present,
                         results_ch.kept_count, results_ch.overflow_flag});
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one item and hold it until it transfers
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      items_ch.valid <= 1'b0;
    end
    @(negedge clk);
    items_ch.valid  <= 1'b1;
    items_ch.kind   <= it.kind;
    items_ch.sample <= it.sample;
    items_ch.rank   <= it.rank;
    do @(posedge clk); while (!items_ch.ready);
  endtask

  // Mostly small magnitudes so duplicates and list churn are common
  function automatic item_t random_item();
    item_t it;
    int    v;
    it.kind = ($urandom_range(4) == 0) ? pwrk_pkg::KIND_READ : pwrk_pkg::KIND_ADD;
    case ($urandom_range(9)) inside
      [0:3]: begin v = $urandom_range(40); it.sample = 16'(v - 20); end
      [4:6]: begin v = $urandom_range(2000); it.sample = 16'(v - 1000); end
      [7:8]: it.sample = 16'($urandom);
      default: begin
        case ($urandom_range(4))
          0:       it.sample = -16'sd32768;
          1:       it.sample = 16'sd32767;
          2:       it.sample = -16'sd1;
          3:       it.sample = 16'sd1;
          default: it.sample = '0;
        endcase
      end
    endcase
    // Ranks around the current fill hit the present/absent boundary
    case ($urandom_range(3)) inside
      [0:1]: it.rank = 8'($urandom);
      2: begin
        v = sb.fill - 1 + $urandom_range(2);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        it.rank = 8'(v);
      end
      default: it.rank = 8'($urandom_range(3));
    endcase
    return it;
  endfunction

  item_t directed_items [24] = '{
    '{pwrk_pkg::KIND_READ, 16'sh7FFF,    8'd0},
    '{pwrk_pkg::KIND_ADD,  16'sd0,       8'd0},
    '{pwrk_pkg::KIND_ADD,  16'sd5,       8'd0},
    '{pwrk_pkg::KIND_ADD,  -16'sd5,      8'd1},
    '{pwrk_pkg::KIND_ADD,  16'sd3,       8'd2},
    '{pwrk_pkg::KIND_ADD,  16'sd7,       8'd0},
    '{pwrk_pkg::KIND_ADD,  -16'sd1,      8'd4},
    '{pwrk_pkg::KIND_ADD,  16'sd1,       8'd5},
    '{pwrk_pkg::KIND_READ, 16'sh0000,    8'd6},
    '{pwrk_pkg::KIND_READ, -16'sd1,      8'd255},
    '{pwrk_pkg::KIND_ADD,  16'sh5555,    8'hAA},
    '{pwrk_pkg::KIND_ADD,  16'shAAAA,    8'h55},
    '{pwrk_pkg::KIND_ADD,  16'sd32767,   8'd0},
    '{pwrk_pkg::KIND_ADD,  -16'sd32768,  8'd0},
    '{pwrk_pkg::KIND_ADD,  -16'sd32767,  8'd1},
    '{pwrk_pkg::KIND_READ, 16'sh1234,    8'd2},
    '{pwrk_pkg::KIND_ADD,  -16'sd32768,  8'd3},
    '{pwrk_pkg::KIND_ADD,  -16'sd32768,  8'd9},
    '{pwrk_pkg::KIND_ADD,  16'sd32767,   8'd10},
    '{pwrk_pkg::KIND_ADD,  -16'sd32768,  8'd11},
    '{pwrk_pkg::KIND_ADD,  -16'sd32768,  8'd12},
    '{pwrk_pkg::KIND_ADD,  -16'sd32768,  8'd13},
    '{pwrk_pkg::KIND_ADD,  16'sd0,       8'd0},
    '{pwrk_pkg::KIND_READ, 16'sh8000,    8'd255}
  };

  // Stimulus and end of run
  initial begin
    int phase;
    rst = 1'b1;
    items_ch.valid  = 1'b0;
    items_ch.kind   = pwrk_pkg::KIND_ADD;
    items_ch.sample = '0;
    items_ch.rank   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items, no idling
    foreach (directed_items[i]) send_item(directed_items[i]);

    // Random items through the idling phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (RANDOM_PER_PHASE) send_item(random_item());
    end
    @(negedge clk);
    items_ch.valid <= 1'b0;

    // Drain, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
